// ===== design/b64d_pkg.sv =====
package b64d_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0a;
    localparam logic [7:0] PAD_EQUALS   = 8'h3d;
    localparam logic [7:0] PAD_DOT      = 8'h2e;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_UNDER   = 8'h5f;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

    localparam logic [5:0] SEXTET_62 = 6'd62;
    localparam logic [5:0] SEXTET_63 = 6'd63;

    // one decoded result as it leaves the decode stage
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       byte_valid;
        logic       eos;
        logic       incomplete;
    } t_result;

    // character to sextet, anything outside both alphabets gives zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            v = c - CHAR_UPPER_A;
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            v = c - CHAR_LOWER_A + 8'd26;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            v = c - CHAR_DIGIT_0 + 8'd52;
        end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
            v = {2'b00, SEXTET_62};
        end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
            v = {2'b00, SEXTET_63};
        end
        return v[5:0];
    endfunction

endpackage

// ===== design/b64d_decode.sv =====
module b64d_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    output b64d_pkg::t_result o_result
);
    import b64d_pkg::*;

    logic [1:0] r_pos;
    logic [5:0] r_prev;
    logic       r_third_pad;
    logic [1:0] n_pos;
    logic [5:0] n_prev;
    logic       n_third_pad;

    logic [5:0] sextet;
    logic       pad;
    logic       newline;
    logic       byte_ok;
    logic [7:0] byte_val;

    assign sextet  = sextet_of(i_char);
    assign pad     = (i_char == PAD_EQUALS) || (i_char == PAD_DOT);
    assign newline = (i_char == NEWLINE_CODE);

    // group step: byte assembly and next group state
    always_comb begin
        n_pos       = r_pos;
        n_prev      = r_prev;
        n_third_pad = r_third_pad;
        byte_ok     = 1'b0;
        byte_val    = 8'd0;
        if (!newline) begin
            case (r_pos)
                2'd0: begin
                    n_prev = sextet;
                    n_pos  = 2'd1;
                end
                2'd1: begin
                    byte_val = {r_prev, sextet[5:4]};
                    byte_ok  = 1'b1;
                    n_prev   = sextet;
                    n_pos    = 2'd2;
                end
                2'd2: begin
                    n_third_pad = pad;
                    if (!pad) begin
                        byte_val = {r_prev[3:0], sextet[5:2]};
                        byte_ok  = 1'b1;
                    end
                    n_prev = sextet;
                    n_pos  = 2'd3;
                end
                default: begin
                    if (!r_third_pad && !pad) begin
                        byte_val = {r_prev[1:0], sextet};
                        byte_ok  = 1'b1;
                    end
                    n_prev      = 6'd0;
                    n_third_pad = 1'b0;
                    n_pos       = 2'd0;
                end
            endcase
        end
    end

    // result toward the output register
    always_comb begin
        o_result.emit       = byte_ok || i_last;
        o_result.data       = byte_ok ? byte_val : 8'd0;
        o_result.byte_valid = byte_ok;
        o_result.eos        = i_last;
        o_result.incomplete = i_last && (n_pos != 2'd0);
    end

    // group state, back to reset after a last-marked character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 2'd0;
            r_prev      <= 6'd0;
            r_third_pad <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_pos       <= 2'd0;
                r_prev      <= 6'd0;
                r_third_pad <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_prev      <= n_prev;
                r_third_pad <= n_third_pad;
            end
        end
    end

endmodule

// ===== design/b64d_out_reg.sv =====
module b64d_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  b64d_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_data,
    output logic              o_last,
    output logic [1:0]        o_user
);
    import b64d_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_res.data;
    assign o_last  = r_res.eos;
    assign o_user  = {r_res.incomplete, r_res.byte_valid};

    // result register, loads when empty or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_fire && i_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_fire && i_result.emit) begin
            r_res <= i_result;
        end
    end

endmodule

// ===== design/base64_decoder_top.sv =====
// base64 character stream decoder
// a character passes the input register, then its result goes to the result register
// throughput: one character per cycle, held back only by m_tready on the result register
// characters that produce no byte and are not last-marked give no result request
// reset: synchronous active-low i_rst_n clears both stage valids and the group state
module base64_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_char
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // end_of_stream
    output logic [1:0] m_tuser    // [0] byte_valid, [1] incomplete_group
);
    import b64d_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       out_free;
    logic       advance;
    t_result    result;

    assign advance  = r_in_valid && out_free;
    assign s_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_char <= s_tdata;
            r_last <= s_tlast;
        end
    end

    b64d_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_char   (r_char),
        .i_last   (r_last),
        .o_result (result)
    );

    b64d_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_result (result),
        .o_free   (out_free),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_data   (m_tdata),
        .o_last   (m_tlast),
        .o_user   (m_tuser)
    );

endmodule

// ===== design/b64d_checker.sv =====
module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // incomplete group only flagged on an end result
    a_incomplete_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("incomplete flag without end of stream");

    // a result without a byte must be an end result
    a_empty_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty result that is not end of stream");

    // no byte means zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("nonzero data without byte flag");

    // nothing offered right after a reset cycle
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind base64_decoder_top b64d_checker u_b64d_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int RANDOM_CHARS = 1250;
    localparam int TAIL_CHARS   = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 250000;

    // one decoded result, fields in the order the checker walks them
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       eos;
        logic       incomplete;
    } t_dec_result;

    // one character request; typed rows carry their own expected result
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        t_dec_result want;
    } t_char_req;

    localparam t_dec_result NO_RESULT = '0;
    localparam t_dec_result BYTE_00   = {8'h00, 3'b100};
    localparam t_dec_result BYTE_FF   = {8'hff, 3'b100};
    localparam t_dec_result END_EMPTY = {8'h00, 3'b010};
    localparam t_dec_result END_SHORT = {8'h00, 3'b011};

    // directed characters, grouped four at a time as the decoder sees them
    localparam t_char_req DIRECTED_ROWS [29] = '{
        // all ones from both alphabets
        {CHAR_SLASH,   1'b0, 1'b0, NO_RESULT},
        {CHAR_SLASH,   1'b0, 1'b1, BYTE_FF},
        {CHAR_UNDER,   1'b0, 1'b1, BYTE_FF},
        {CHAR_UNDER,   1'b0, 1'b1, BYTE_FF},
        // range ends and a newline inside a group
        {CHAR_LOWER_Z, 1'b0, 1'b0, NO_RESULT},
        {CHAR_PLUS,    1'b0, 1'b0, NO_RESULT},
        {NEWLINE_CODE, 1'b0, 1'b0, NO_RESULT},
        {CHAR_DIGIT_9, 1'b0, 1'b0, NO_RESULT},
        {CHAR_MINUS,   1'b0, 1'b0, NO_RESULT},
        // characters outside the alphabet, then two '=' pads
        {8'h00,        1'b0, 1'b0, NO_RESULT},
        {8'hff,        1'b0, 1'b1, BYTE_00},
        {PAD_EQUALS,   1'b0, 1'b0, NO_RESULT},
        {PAD_EQUALS,   1'b0, 1'b0, NO_RESULT},
        // '.' as fourth character only
        {"Q",          1'b0, 1'b0, NO_RESULT},
        {"U",          1'b0, 1'b0, NO_RESULT},
        {"E",          1'b0, 1'b0, NO_RESULT},
        {PAD_DOT,      1'b0, 1'b0, NO_RESULT},
        // padded third character suppresses a real fourth one
        {CHAR_UPPER_A, 1'b0, 1'b0, NO_RESULT},
        {CHAR_UPPER_A, 1'b0, 1'b1, BYTE_00},
        {PAD_DOT,      1'b0, 1'b0, NO_RESULT},
        {"B",          1'b0, 1'b0, NO_RESULT},
        // stream ends on a byte part way through a group
        {"S",          1'b0, 1'b0, NO_RESULT},
        {"Q",          1'b1, 1'b0, NO_RESULT},
        // stream ends on a newline at a group boundary
        {NEWLINE_CODE, 1'b1, 1'b1, END_EMPTY},
        // stream of a single character
        {"T",          1'b1, 1'b1, END_SHORT},
        // stream ends on padding that closes the group
        {"Q",          1'b0, 1'b0, NO_RESULT},
        {PAD_EQUALS,   1'b0, 1'b0, NO_RESULT},
        {PAD_EQUALS,   1'b0, 1'b0, NO_RESULT},
        {PAD_EQUALS,   1'b1, 1'b1, END_EMPTY}
    };

    logic       i_clk;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] in_char
    logic       s_tlast  = 1'b0; // is_last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [7:0] out_byte
    logic       m_tlast;         // end_of_stream
    logic [1:0] m_tuser;         // [0] byte_valid, [1] incomplete_group

    // decoder state as predicted
    logic [1:0]  grp_pos   = '0;
    logic [5:0]  prev_sx   = '0;
    logic        third_pad = 1'b0;

    t_dec_result pending_bytes[$];
    t_char_req   char_queue[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          idle_on     = 1'b0;

    base64_decoder_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sextet value of one character, zero outside both alphabets
    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return 6'(c - CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return 6'(c - CHAR_LOWER_A + 8'd26);
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return 6'(c - CHAR_DIGIT_0 + 8'd52);
        if (c == CHAR_PLUS || c == CHAR_MINUS) return SEXTET_62;
        if (c == CHAR_SLASH || c == CHAR_UNDER) return SEXTET_63;
        return 6'd0;
    endfunction

    // advance the predicted group state by one character, tell whether a result follows
    function automatic bit decode_char(input logic [7:0] c, input logic last,
                                       output t_dec_result r);
        logic [5:0] sx;
        logic       pad;
        r = NO_RESULT;
        if (c != NEWLINE_CODE) begin
            sx  = char_to_sextet(c);
            pad = (c == PAD_EQUALS || c == PAD_DOT);
            case (grp_pos)
                2'd0: begin
                    prev_sx = sx;
                end
                2'd1: begin
                    r.data       = {prev_sx, sx[5:4]};
                    r.byte_valid = 1'b1;
                    prev_sx      = sx;
                end
                2'd2: begin
                    third_pad = pad;
                    if (!pad) begin
                        r.data       = {prev_sx[3:0], sx[5:2]};
                        r.byte_valid = 1'b1;
                    end
                    prev_sx = sx;
                end
                default: begin
                    if (!third_pad && !pad) begin
                        r.data       = {prev_sx[1:0], sx};
                        r.byte_valid = 1'b1;
                    end
                    prev_sx   = '0;
                    third_pad = 1'b0;
                end
            endcase
            grp_pos = grp_pos + 2'd1;
        end
        r.eos        = last;
        r.incomplete = last && (grp_pos != 2'd0);
        if (last) begin
            grp_pos   = '0;
            prev_sx   = '0;
            third_pad = 1'b0;
        end
        return r.byte_valid || last;
    endfunction

    // random character of either alphabet
    function automatic logic [7:0] alphabet_char(input int idx);
        if (idx < 26) return CHAR_UPPER_A + 8'(idx);
        if (idx < 52) return CHAR_LOWER_A + 8'(idx - 26);
        if (idx < 62) return CHAR_DIGIT_0 + 8'(idx - 52);
        if (idx == 62) return ($urandom_range(0, 1) != 0) ? CHAR_MINUS : CHAR_PLUS;
        return ($urandom_range(0, 1) != 0) ? CHAR_UNDER : CHAR_SLASH;
    endfunction

    function automatic logic [7:0] pad_char();
        return ($urandom_range(0, 1) != 0) ? PAD_DOT : PAD_EQUALS;
    endfunction

    // one random stream: mostly whole groups, some padded, some cut short, some noise
    task automatic queue_stream(output int counted);
        logic [7:0] chars[$];
        t_char_req  item;
        int         kind;
        int         groups;
        int         n;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            n = $urandom_range(1, 12);
            repeat (n) chars = {chars, 8'($urandom_range(0, 255))};
        end else begin
            groups = $urandom_range(1, 6);
            repeat (groups * 4) chars = {chars, alphabet_char($urandom_range(0, 63))};
            case ($urandom_range(0, 4))
                1: begin
                    chars[chars.size() - 1] = pad_char();
                end
                2: begin
                    chars[chars.size() - 1] = pad_char();
                    chars[chars.size() - 2] = pad_char();
                end
                3: begin
                    chars[chars.size() - 2] = pad_char();
                end
                default: begin
                end
            endcase
            // broken stream, ends inside its last group
            if (kind == 2) begin
                n = $urandom_range(1, 3);
                repeat (n) void'(chars.pop_back());
                if (chars.size() == 0) chars = {chars, alphabet_char($urandom_range(0, 63))};
            end
        end
        counted = chars.size();
        foreach (chars[i]) begin
            if ($urandom_range(0, 11) == 0) begin
                item       = {NEWLINE_CODE, 1'b0, 1'b0, NO_RESULT};
                char_queue = {char_queue, item};
                counted++;
            end
            item       = {chars[i], (i == chars.size() - 1), 1'b0, NO_RESULT};
            char_queue = {char_queue, item};
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // character requests, prediction at acceptance
    initial begin
        int          total;
        int          n;
        bit          quiet;
        bit          has_result;
        t_char_req   req;
        t_dec_result res;
        total = 0;
        quiet = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED_ROWS[i]) char_queue = {char_queue, DIRECTED_ROWS[i]};
        while (total < RANDOM_CHARS) begin
            queue_stream(n);
            total += n;
        end
        for (int i = 0; i < char_queue.size(); i++) begin
            if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            idle_on = !quiet && (i < char_queue.size() - TAIL_CHARS);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            req = char_queue[i];
            s_tvalid <= 1'b1;
            s_tdata  <= req.ch;
            s_tlast  <= req.last;
            do @(posedge i_clk); while (!s_tready);
            has_result = decode_char(req.ch, req.last, res);
            if (req.typed) begin
                pending_bytes = {pending_bytes, req.want};
            end else if (has_result) begin
                pending_bytes = {pending_bytes, res};
            end
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // result side ready with random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_dec_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected result, data %02h last %0b user %02b",
                                          m_tdata, m_tlast, m_tuser));
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
                if (m_tuser[0] !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                              m_tuser[0], want.byte_valid));
                if (m_tlast !== want.eos)
                    report_mismatch($sformatf("end_of_stream %0b, expected %0b", m_tlast, want.eos));
                if (m_tuser[1] !== want.incomplete)
                    report_mismatch($sformatf("incomplete_group %0b, expected %0b",
                                              m_tuser[1], want.incomplete));
            end
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
design/b64d_pkg.sv
design/b64d_decode.sv
design/b64d_out_reg.sv
design/base64_decoder_top.sv
design/b64d_checker.sv
verif/tb_top.sv
